// File: hdl/mfhp_pkg.sv
// ----------------------------------------------------------------------------
// mfhp_pkg
// shared types, status codes and decode tables for the frame header parser
// ----------------------------------------------------------------------------
`default_nettype none

package mfhp_pkg;

  // result status codes
  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_OTHER = 2'd1;
  localparam logic [1:0] STATUS_L3    = 2'd2;

  localparam logic [7:0] SYNC_BYTE   = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE = 4'hF;
  localparam logic [3:0] BITRATE_BAD_IDX = 4'd15;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  bitrate_kbps;
    logic        bitrate_bad;
    logic [15:0] sample_rate_hz;
    logic        copyright_flag;
    logic        original_flag;
    logic [31:0] header_word;
  } out_t;

  // pending result between tracker and decoder
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] word;
  } cand_t;

  // mpeg-1 layer iii bitrate table, kbps
  function automatic logic [8:0] kbps_lookup(input logic [3:0] idx);
    logic [8:0] v;
    case (idx)
      4'd1:    v = 9'd32;
      4'd2:    v = 9'd40;
      4'd3:    v = 9'd48;
      4'd4:    v = 9'd56;
      4'd5:    v = 9'd64;
      4'd6:    v = 9'd80;
      4'd7:    v = 9'd96;
      4'd8:    v = 9'd112;
      4'd9:    v = 9'd128;
      4'd10:   v = 9'd160;
      4'd11:   v = 9'd192;
      4'd12:   v = 9'd224;
      4'd13:   v = 9'd256;
      4'd14:   v = 9'd320;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // mpeg-1 sample rate table, hz
  function automatic logic [15:0] rate_lookup(input logic [1:0] idx);
    logic [15:0] v;
    case (idx)
      2'd0:    v = 16'd44100;
      2'd1:    v = 16'd48000;
      2'd2:    v = 16'd32000;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mfhp_track.sv
// ----------------------------------------------------------------------------
// mfhp_track
// sync search and header capture state, one byte per accepted item
// ----------------------------------------------------------------------------
`default_nettype none

module mfhp_track (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          acc,
  input  wire mfhp_pkg::in_t item,
  output mfhp_pkg::cand_t    cand
);

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_CAPTURE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [31:0] shift_r, shift_nxt;

  always_comb begin
    logic [7:0] b;
    b = item.data_byte;
    phase_nxt      = phase_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    count_nxt      = count_r;
    shift_nxt      = shift_r;
    cand           = '0;

    case (phase_r)
      PH_SEARCH: begin
        if (prev_valid_r && prev_r == mfhp_pkg::SYNC_BYTE &&
            b[7:4] == mfhp_pkg::SYNC_NIBBLE) begin
          shift_nxt = {16'd0, mfhp_pkg::SYNC_BYTE, b};
          count_nxt = 2'd2;
          phase_nxt = PH_CAPTURE;
        end
        prev_nxt       = b;
        prev_valid_nxt = 1'b1;
      end
      PH_CAPTURE: begin
        shift_nxt = {shift_r[23:0], b};
        if (count_r == 2'd3) begin
          cand.valid = 1'b1;
          cand.found = 1'b1;
          cand.word  = {shift_r[23:0], b};
          phase_nxt  = PH_DONE;
          count_nxt  = 2'd0;
        end else begin
          count_nxt = count_r + 2'd1;
        end
      end
      default: ;
    endcase

    if (item.last_byte) begin
      // stream ended without a complete header
      if (!cand.valid && (phase_nxt == PH_SEARCH || phase_nxt == PH_CAPTURE)) begin
        cand.valid = 1'b1;
      end
      phase_nxt      = PH_SEARCH;
      prev_nxt       = 8'd0;
      prev_valid_nxt = 1'b0;
      count_nxt      = 2'd0;
      shift_nxt      = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEARCH;
      prev_r       <= 8'd0;
      prev_valid_r <= 1'b0;
      count_r      <= 2'd0;
      shift_r      <= 32'd0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      count_r      <= count_nxt;
      shift_r      <= shift_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mfhp_decode.sv
// ----------------------------------------------------------------------------
// mfhp_decode
// field decode of a captured header into one result item
// ----------------------------------------------------------------------------
`default_nettype none

module mfhp_decode (
  input  wire mfhp_pkg::cand_t cand,
  output mfhp_pkg::out_t       res
);

  logic       is_l3;
  logic [3:0] bidx;

  assign bidx  = cand.word[15:12];
  assign is_l3 = cand.word[19] && cand.word[18:17] == 2'b01;

  always_comb begin
    res = '0;
    if (cand.found) begin
      res.header_word = cand.word;
      if (is_l3) begin
        res.status         = mfhp_pkg::STATUS_L3;
        res.bitrate_kbps   = mfhp_pkg::kbps_lookup(bidx);
        res.bitrate_bad    = (bidx == mfhp_pkg::BITRATE_BAD_IDX);
        res.sample_rate_hz = mfhp_pkg::rate_lookup(cand.word[11:10]);
        res.copyright_flag = cand.word[3];
        res.original_flag  = cand.word[2];
      end else begin
        res.status = mfhp_pkg::STATUS_OTHER;
      end
    end else begin
      res.status = mfhp_pkg::STATUS_NONE;
    end
  end

endmodule

`default_nettype wire

// File: hdl/mp3_frame_header_parser.sv
// ----------------------------------------------------------------------------
// mp3_frame_header_parser
// finds the first mpeg frame sync in a byte stream and reports its header
// ----------------------------------------------------------------------------
//
//  channel | ports                        | dir | payload
//  --------+------------------------------+-----+------------------------------
//  input   | in_valid, in_stall, in_data  | in  | one file byte + last marker
//  result  | out_valid, out_stall,out_data| out | status, rates, flags, header
//
//  one byte is taken every cycle while in_stall is low; a result moves
//  through tracker state -> candidate register -> output register
//  a two-entry output buffer (output register plus skid) lets input keep
//  flowing while a finished result waits; in_stall rises only when the
//  candidate register and both output entries are full
//  rst_n is synchronous and clears all control state
//
`default_nettype none

module mp3_frame_header_parser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire mfhp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output mfhp_pkg::out_t      out_data
);

  logic            in_acc;
  mfhp_pkg::cand_t cand;
  mfhp_pkg::cand_t s1_r;          // candidate register, valid bit inside
  mfhp_pkg::out_t  dec;
  mfhp_pkg::out_t  out_data_r;
  logic            out_valid_r;
  mfhp_pkg::out_t  skid_data_r;
  logic            skid_valid_r;
  logic            s1_move;
  logic            out_free;

  // candidate moves on whenever the skid entry is empty
  assign s1_move  = s1_r.valid && !skid_valid_r;
  assign in_stall = s1_r.valid && skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // sync search and header capture
  mfhp_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .item  (in_data),
    .cand  (cand)
  );

  // table decode of the registered candidate
  mfhp_decode u_decode (
    .cand (s1_r),
    .res  (dec)
  );

  // candidate register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (in_acc) begin
      s1_r.valid <= cand.valid;
      s1_r.found <= cand.found;
      s1_r.word  <= cand.word;
    end else if (s1_move) begin
      s1_r.valid <= 1'b0;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || s1_move;
      skid_valid_r <= 1'b0;
    end else if (s1_move) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : dec;
    end else if (s1_move) begin
      skid_data_r <= dec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
